### hdl/efd_pkg.sv
// Shared types and constants for the escaped frame deframer.
package efd_pkg;

  localparam int LEN_W  = 7;
  localparam int KIND_W = 3;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ESC = 8'h1B;

  localparam logic [KIND_W-1:0] K_DATA  = 3'd0;
  localparam logic [KIND_W-1:0] K_EMPTY = 3'd1;
  localparam logic [KIND_W-1:0] K_LONG  = 3'd2;
  localparam logic [KIND_W-1:0] K_OVF   = 3'd3;
  localparam logic [KIND_W-1:0] K_PROTO = 3'd4;
  localparam logic [KIND_W-1:0] K_DROP  = 3'd5;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_RUN,
    FS_DONE
  } front_state_t;

  typedef enum logic {
    BS_IDLE,
    BS_DRAIN
  } back_state_t;

  typedef enum logic [1:0] {
    OP_WRITE,  // store data at address len
    OP_EMIT,   // single result: kind, len
    OP_DRAIN   // send len stored bytes as a run
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KIND_W-1:0] kind;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

### hdl/escaped_frame_deframer.sv
// Top level of the SOH/EOT/ESC byte-stuffed frame deframer.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_tvalid / s_tready           s_tdata[7:0] rx_byte
//  m_axis    out  m_tvalid / m_tready           tdata: payload_byte, frame_length;
//                                               tuser: kind; tlast: last
//  cfg       in   cfg_valid / cfg_ready (=1)    cfg_data[6:0] max_len
//
// A byte is taken every cycle while the 4-entry command queue has room.
// The back end stores each data byte and emits each single result as one beat; a frame
// drains as a run of beats from the payload memory, one beat per cycle while the output is free.
// rst is synchronous; it clears frame state, the queue and the output register.
// Output stalls back up through the queue to s_tready; max_len resets to 64.
module escaped_frame_deframer #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [14:8] frame_length, [15] zero
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import efd_pkg::*;

  cmd_t       q_cmd, q_head;
  logic       q_push, q_pop, q_full, q_empty;
  logic [7:0] out_byte;
  logic [6:0] out_len;

  assign cfg_ready = 1'b1;

  efd_front #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  efd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  efd_back #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_kind (m_tuser),
    .out_byte (out_byte),
    .out_last (m_tlast),
    .out_len  (out_len)
  );

  assign m_tdata = {1'b0, out_len, out_byte};

  // error and status results are single beats
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != K_DATA |-> m_tlast)
    else $error("non-data beat without tlast");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != K_DATA |-> m_tdata[7:0] == 8'h00)
    else $error("payload byte set on non-data beat");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == K_OVF || m_tuser == K_PROTO || m_tuser == K_DROP)
      |-> m_tdata[14:8] == 7'd0)
    else $error("frame length set on error beat");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("command pushed into full queue");

endmodule

### hdl/efd_front.sv
// Front end: byte classification, frame state and command generation.
module efd_front #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic                cfg_valid,
  input  logic [6:0]          cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output efd_pkg::cmd_t       q_cmd
);
  import efd_pkg::*;

  front_state_t     state, state_next;
  logic             esc, esc_next;
  logic [LEN_W-1:0] fill, fill_next;
  logic [LEN_W-1:0] max_len;
  logic             acc;
  logic             special;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign special  = (in_byte == CH_SOH) || (in_byte == CH_EOT) || (in_byte == CH_ESC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FS_IDLE;
      esc     <= 1'b0;
      fill    <= '0;
      max_len <= LEN_W'(64);
    end else begin
      state <= state_next;
      esc   <= esc_next;
      fill  <= fill_next;
      if (cfg_valid) begin
        max_len <= cfg_data;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    esc_next   = esc;
    fill_next  = fill;
    if (acc) begin
      if (esc && !special) begin
        state_next = FS_IDLE;
        fill_next  = '0;
        esc_next   = 1'b0;
      end else if (!esc && in_byte == CH_SOH) begin
        fill_next  = '0;
        state_next = (state == FS_DONE) ? FS_IDLE : FS_RUN;
      end else if (!esc && in_byte == CH_EOT) begin
        if (state == FS_RUN) begin
          state_next = (fill > max_len) ? FS_DONE : FS_IDLE;
        end
      end else if (!esc && in_byte == CH_ESC) begin
        esc_next = 1'b1;
      end else begin
        // plain data or an escaped special byte
        esc_next = 1'b0;
        if (state == FS_RUN) begin
          if (fill >= LEN_W'(FRAME_CAPACITY)) begin
            state_next = FS_IDLE;
            fill_next  = '0;
          end else begin
            fill_next = fill + 1'b1;
          end
        end
      end
    end
  end

  // command to the back end
  always_comb begin
    q_push = 1'b0;
    q_cmd  = '{op: OP_EMIT, kind: K_DATA, data: 8'h00, len: '0};
    if (acc) begin
      if (esc && !special) begin
        q_push     = 1'b1;
        q_cmd.kind = K_PROTO;
      end else if (!esc && in_byte == CH_SOH) begin
        if (state == FS_DONE) begin
          q_push     = 1'b1;
          q_cmd.kind = K_DROP;
        end
      end else if (!esc && in_byte == CH_EOT) begin
        if (state == FS_RUN) begin
          q_push = 1'b1;
          if (fill > max_len) begin
            q_cmd.kind = K_LONG;
            q_cmd.len  = fill;
          end else if (fill == '0) begin
            q_cmd.kind = K_EMPTY;
          end else begin
            q_cmd.op  = OP_DRAIN;
            q_cmd.len = fill;
          end
        end
      end else if (!esc && in_byte == CH_ESC) begin
        q_push = 1'b0;
      end else begin
        if (state == FS_RUN) begin
          q_push = 1'b1;
          if (fill >= LEN_W'(FRAME_CAPACITY)) begin
            q_cmd.kind = K_OVF;
          end else begin
            q_cmd.op   = OP_WRITE;
            q_cmd.data = in_byte;
            q_cmd.len  = fill;
          end
        end
      end
    end
  end

endmodule

### hdl/efd_fifo.sv
// Short command queue between front and back end.
module efd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  efd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output efd_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import efd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = 2;

  cmd_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hdl/efd_back.sv
// Back end: payload store, run drain and output register.
module efd_back #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  efd_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [6:0]    out_len
);
  import efd_pkg::*;

  localparam int AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;

  back_state_t      state, state_next;
  logic [7:0]       mem [FRAME_CAPACITY];
  logic [7:0]       mem_q;
  logic [LEN_W-1:0] idx, cnt, idx_inc;
  logic             out_free;
  logic             we, rd_en, load, drain_start, drain_step, drain_last;
  logic [AW-1:0]    raddr;
  logic [KIND_W-1:0] load_kind;
  logic [7:0]       load_byte;
  logic [LEN_W-1:0] load_len;

  assign out_free   = !out_valid || out_ready;
  assign idx_inc    = idx + 1'b1;
  assign drain_last = (idx_inc == cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (!empty && head.op == OP_DRAIN) begin
          state_next = BS_DRAIN;
        end
      end
      BS_DRAIN: begin
        if (out_free && drain_last) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    we          = 1'b0;
    rd_en       = 1'b0;
    raddr       = '0;
    load        = 1'b0;
    drain_start = 1'b0;
    drain_step  = 1'b0;
    load_kind   = head.kind;
    load_byte   = 8'h00;
    load_len    = head.len;
    unique case (state)
      BS_IDLE: begin
        if (!empty) begin
          unique case (head.op)
            OP_WRITE: begin
              pop = 1'b1;
              we  = 1'b1;
            end
            OP_EMIT: begin
              if (out_free) begin
                pop  = 1'b1;
                load = 1'b1;
              end
            end
            OP_DRAIN: begin
              pop         = 1'b1;
              rd_en       = 1'b1;
              drain_start = 1'b1;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BS_DRAIN: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = K_DATA;
          load_byte  = mem_q;
          load_len   = cnt;
          drain_step = !drain_last;
          rd_en      = !drain_last;
          raddr      = idx_inc[AW-1:0];
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[head.len[AW-1:0]] <= head.data;
    end
    if (rd_en) begin
      mem_q <= mem[raddr];
    end
    if (drain_start) begin
      idx <= '0;
      cnt <= head.len;
    end else if (drain_step) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= load_kind;
      out_byte <= load_byte;
      out_last <= (state == BS_DRAIN) ? drain_last : 1'b1;
      out_len  <= load_len;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the escaped frame deframer: directed table, then random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efd_pkg::*;

  localparam int FRAME_CAP    = 64;
  localparam int QUIET_CYCLES = 70;

  localparam logic [7:0] SPECIALS [3] = '{CH_SOH, CH_EOT, CH_ESC};

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [7:0]        data;
    logic              last;
    logic [LEN_W-1:0]  len;
  } beat_t;

  // cfg rows write max_len from val; pinned rows carry a hand-written result
  typedef struct {
    bit                cfg;
    logic [7:0]        val;
    int                reps;
    bit                pinned;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  // shadow copy of the deframer
  logic [7:0]       shadow_store [FRAME_CAP];
  logic [LEN_W-1:0] shadow_fill  = '0;
  logic             shadow_esc   = 1'b0;
  front_state_t     shadow_state = FS_IDLE;
  logic [6:0]       shadow_max   = 7'd64;

  beat_t       pending_beats [$];
  beat_t       head_beat;
  int unsigned mismatches = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  logic [8:0]  stall_phase = '0;

  stim_row_t directed [41] = '{
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},  // end outside a frame
    '{1'b0, 8'h55,    1,  1'b0, K_DATA,  7'd0},  // data outside a frame
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},  // escaped special, no frame: dropped
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b1, K_EMPTY, 7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h00,    1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'hFF,    1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h41,    1,  1'b1, K_PROTO, 7'd0},  // escaped plain byte
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h12,    1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},  // restart drops the partial frame
    '{1'b0, 8'h34,    1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'hA5,    64, 1'b0, K_DATA,  7'd0},  // store exactly full
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h5A,    65, 1'b1, K_OVF,   7'd0},  // one past capacity
    '{1'b1, 8'd0,     1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h7F,    1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b1, K_LONG,  7'd1},
    '{1'b0, 8'h33,    1,  1'b0, K_DATA,  7'd0},  // ignored while finished
    '{1'b0, CH_EOT,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b1, K_DROP,  7'd0},
    '{1'b0, CH_SOH,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, CH_EOT,   1,  1'b1, K_EMPTY, 7'd0},
    '{1'b0, CH_ESC,   1,  1'b0, K_DATA,  7'd0},
    '{1'b0, 8'h00,    1,  1'b1, K_PROTO, 7'd0},
    '{1'b1, 8'd127,   1,  1'b0, K_DATA,  7'd0}
  };

  escaped_frame_deframer #(
    .FRAME_CAPACITY(FRAME_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stall pattern: free run, coin flip, 3 of 4, mostly stalled
  always @(posedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (stall_phase[1:0] != 2'd0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic void abort_frame(input logic [KIND_W-1:0] kind, ref beat_t res[$]);
    shadow_fill  = '0;
    shadow_esc   = 1'b0;
    shadow_state = FS_IDLE;
    res.push_back('{kind, 8'h00, 1'b1, 7'd0});
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, ref beat_t res[$]);
    logic             special;
    logic [LEN_W-1:0] n;
    res.delete();
    special = (b == CH_SOH) || (b == CH_EOT) || (b == CH_ESC);
    if (shadow_esc) begin
      if (!special) begin
        abort_frame(K_PROTO, res);
        return;
      end
      shadow_esc = 1'b0;
    end else if (b == CH_SOH) begin
      if (shadow_state == FS_DONE) begin
        abort_frame(K_DROP, res);
        return;
      end
      shadow_fill  = '0;
      shadow_state = FS_RUN;
      return;
    end else if (b == CH_EOT) begin
      if (shadow_state != FS_RUN) return;
      n = shadow_fill;
      if (n > shadow_max) begin
        // refused frame stays finished and keeps its count
        shadow_state = FS_DONE;
        res.push_back('{K_LONG, 8'h00, 1'b1, n});
        return;
      end
      shadow_state = FS_IDLE;
      if (n == 0) res.push_back('{K_EMPTY, 8'h00, 1'b1, 7'd0});
      else
        for (int k = 0; k < int'(n); k++)
          res.push_back('{K_DATA, shadow_store[k], 1'(k + 1 == int'(n)), n});
      return;
    end else if (b == CH_ESC) begin
      shadow_esc = 1'b1;
      return;
    end
    if (shadow_state == FS_RUN) begin
      if (shadow_fill >= FRAME_CAP) begin
        abort_frame(K_OVF, res);
        return;
      end
      shadow_store[shadow_fill[5:0]] = b;
      shadow_fill = shadow_fill + 7'd1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                           input logic [KIND_W-1:0] kind = K_DATA,
                           input logic [LEN_W-1:0] len = '0);
    int    gap;
    beat_t fresh [$];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sent_items % 128 < 40 || $urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    sent_items++;
    deframe_byte(b, fresh);
    if (pinned && fresh.size() != 0) pending_beats.push_back('{kind, 8'h00, 1'b1, len});
    else foreach (fresh[i]) pending_beats.push_back(fresh[i]);
  endtask

  // stop sending until every beat has come out, then let the front end go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [6:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_max = value;
  endtask

  task automatic send_payload(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) b = SPECIALS[$urandom_range(0, 2)];
      else b = 8'($urandom_range(0, 255));
      if (b == CH_SOH || b == CH_EOT || b == CH_ESC) send_byte(CH_ESC);
      send_byte(b);
    end
  endtask

  task automatic send_frame(input int count);
    send_byte(CH_SOH);
    send_payload(count);
    send_byte(CH_EOT);
  endtask

  task automatic random_phase(input logic [6:0] limit, input int budget);
    int         goal;
    int         pick;
    int         len;
    logic [7:0] b;
    write_max_len(limit);
    goal = sent_items + budget;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame($urandom_range(0, 10));
      end else if (pick < 70) begin
        // length around the limit
        len = int'(shadow_max) + $urandom_range(0, 2) - 1;
        if (len < 0) len = 0;
        if (len > FRAME_CAP) len = FRAME_CAP;
        send_frame(len);
      end else if (pick < 73) begin
        send_frame(FRAME_CAP + $urandom_range(0, 1));
      end else if (pick < 80) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        // escape followed by a plain byte
        send_byte(CH_SOH);
        send_payload($urandom_range(0, 4));
        send_byte(CH_ESC);
        b = 8'($urandom_range(0, 255));
        if (b == CH_SOH || b == CH_EOT || b == CH_ESC) b = b ^ 8'h80;
        send_byte(b);
      end else if (pick < 94) begin
        // no end marker; a following item may extend, close or discard it
        send_byte(CH_SOH);
        send_payload($urandom_range(0, 6));
      end else begin
        send_byte(CH_ESC);
        send_byte(SPECIALS[$urandom_range(0, 2)]);
        send_byte(CH_EOT);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $error("beat with nothing expected: kind %0d, data %0h, last %0b, length %0d",
               m_tuser, m_tdata[7:0], m_tlast, m_tdata[14:8]);
        mismatches++;
      end else begin
        head_beat = pending_beats.pop_front();
        check_field("kind", 8'(head_beat.kind), 8'(m_tuser));
        check_field("payload_byte", head_beat.data, m_tdata[7:0]);
        check_field("last", 8'(head_beat.last), 8'(m_tlast));
        check_field("frame_length", 8'(head_beat.len), 8'(m_tdata[14:8]));
        check_field("tdata pad", 8'h00, 8'(m_tdata[15]));
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 7'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].cfg) write_max_len(directed[i].val[6:0]);
      else
        repeat (directed[i].reps)
          send_byte(directed[i].val, directed[i].pinned, directed[i].kind, directed[i].len);
    end

    random_phase(7'd127, 8);
    random_phase(7'd0, 4);
    random_phase(7'd1, 4);
    random_phase(7'd63, 6);
    random_phase(7'd64, 6);
    random_phase(7'($urandom_range(2, 62)), 6);
    settle();

    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
